[rtl/core/sa24_pkg.sv]
// sa24_pkg: item types, action and error codes for the 24-bit stack alu
// no dependencies
`default_nettype none
package sa24_pkg;

    localparam int WORD_W  = 24;
    localparam int DEPTH   = 256;
    localparam int ADDR_W  = 8;
    localparam int SP_W    = 9;

    typedef enum logic [4:0] {
        ACT_NOP   = 5'd0,
        ACT_ADD   = 5'd1,
        ACT_SUB   = 5'd2,
        ACT_MUL   = 5'd3,
        ACT_DIV   = 5'd4,
        ACT_MOD   = 5'd5,
        ACT_INC   = 5'd6,
        ACT_DEC   = 5'd7,
        ACT_AND   = 5'd8,
        ACT_OR    = 5'd9,
        ACT_XOR   = 5'd10,
        ACT_NOT   = 5'd11,
        ACT_PUSH  = 5'd12,
        ACT_DIGIT = 5'd13,
        ACT_POP   = 5'd14,
        ACT_DUP   = 5'd15,
        ACT_SWAP  = 5'd16,
        ACT_INDEX = 5'd17,
        ACT_EXP   = 5'd18,
        ACT_PEEK  = 5'd19
    } t_action;

    typedef enum logic [2:0] {
        ERR_OK    = 3'd0,
        ERR_UFLOW = 3'd1,
        ERR_DIV0  = 3'd2,
        ERR_FULL  = 3'd3,
        ERR_RANGE = 3'd4
    } t_err;

    localparam logic [WORD_W-1:0] ASCII_ZERO = 24'd48;

    typedef struct packed {
        logic [4:0]               action;
        logic signed [WORD_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] top_value;
        logic [SP_W-1:0]          depth;
        logic                     top_negative;
        logic [2:0]               error_code;
        logic                     yield;
    } t_out_item;

endpackage
`default_nettype wire

[rtl/core/stack_alu_24bit_top.sv]
// stack_alu_24bit_top: stack machine execution unit on a 256-word stack memory
// depends on sa24_pkg
`default_nettype none
// One stack instruction per input item, one result item per input item. The
// stack lives in a 256 x 24 synchronous memory with two read ports and one
// write port; the top two entries are read while idle, so most actions are
// accepted, then executed and written back. Swap and index add a step (a
// second write or a second read of the memory). Div and mod use a radix-2
// restoring divider that retires one quotient bit per cycle. Items are
// taken one at a time; a finished result waits in the output register while
// the next item is accepted. Stack contents are undefined after reset; only
// the stack pointer, the state and the output valid are cleared.
module stack_alu_24bit_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  sa24_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output sa24_pkg::t_out_item  o_out_data
);
    import sa24_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_EX, S_SWP, S_IDX, S_DIV} t_state;

    t_state                    r_state;
    logic [SP_W-1:0]           r_sp;
    logic [4:0]                r_act;
    logic signed [WORD_W-1:0]  r_pv;
    logic signed [WORD_W-1:0]  r_rd_top;
    logic signed [WORD_W-1:0]  r_rd_nxt;
    logic [WORD_W-1:0]         mem [DEPTH];

    // divider state
    logic [WORD_W-1:0]         r_quo;
    logic [WORD_W-1:0]         r_rem;
    logic [WORD_W-1:0]         r_dvs;
    logic [4:0]                r_cnt;
    logic                      r_qneg;
    logic                      r_rneg;

    logic                      free;
    logic                      accept;
    logic [ADDR_W-1:0]         addr_top;
    logic [ADDR_W-1:0]         addr_nxt;
    logic [ADDR_W-1:0]         addr_idx;

    // finish/commit controls
    logic                      f_go;
    logic                      f_wr;
    logic [ADDR_W-1:0]         f_addr;
    logic [WORD_W-1:0]         f_data;
    logic [SP_W-1:0]           f_sp;
    logic [WORD_W-1:0]         f_top;
    t_err                      f_err;
    logic                      f_yld;
    logic                      x_swap;
    logic                      x_div;
    logic                      x_idx;

    logic                      has1;
    logic                      has2;
    logic                      full;
    logic [2*WORD_W-1:0]       prod;
    logic [WORD_W-1:0]         alu;
    logic [WORD_W:0]           rem_sh;
    logic [WORD_W:0]           rem_sub;
    logic [WORD_W-1:0]         div_res;
    logic                      div_done;

    assign accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign free     = !o_out_valid || i_out_ready;
    assign addr_top = r_sp[ADDR_W-1:0] - ADDR_W'(1);
    assign addr_nxt = r_sp[ADDR_W-1:0] - ADDR_W'(2);
    assign addr_idx = addr_nxt - r_rd_top[ADDR_W-1:0];
    assign has1     = (r_sp != '0);
    assign has2     = (r_sp > SP_W'(1));
    assign full     = (r_sp == SP_W'(DEPTH));
    assign prod     = r_rd_nxt * r_rd_top;
    assign div_done = (r_cnt == 5'(WORD_W));

    // two-operand arithmetic and logic
    always_comb begin
        unique case (r_act)
            ACT_ADD: alu = r_rd_nxt + r_rd_top;
            ACT_SUB: alu = r_rd_nxt - r_rd_top;
            ACT_MUL: alu = prod[WORD_W-1:0];
            ACT_AND: alu = r_rd_nxt & r_rd_top;
            ACT_OR:  alu = r_rd_nxt | r_rd_top;
            default: alu = r_rd_nxt ^ r_rd_top;
        endcase
    end

    // divider step and signed result
    assign rem_sh  = {r_rem, r_quo[WORD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    always_comb begin
        if (r_act == ACT_DIV) begin
            div_res = r_qneg ? (WORD_W'(0) - r_quo) : r_quo;
        end else begin
            div_res = r_rneg ? (WORD_W'(0) - r_rem) : r_rem;
        end
    end

    // execute decode: what to write, new depth and the result item
    always_comb begin
        f_go   = 1'b0;
        f_wr   = 1'b0;
        f_addr = addr_top;
        f_data = r_rd_top;
        f_sp   = r_sp;
        f_top  = r_rd_top;
        f_err  = ERR_OK;
        f_yld  = 1'b0;
        x_swap = 1'b0;
        x_div  = 1'b0;
        x_idx  = 1'b0;
        unique case (r_state)
            S_EX: begin
                f_go = 1'b1;
                unique case (r_act)
                    ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD,
                    ACT_AND, ACT_OR, ACT_XOR, ACT_SWAP: begin
                        if (!has2) begin
                            f_err = ERR_UFLOW;
                        end else if ((r_act == ACT_DIV || r_act == ACT_MOD) &&
                                     r_rd_top == '0) begin
                            f_err = ERR_DIV0;
                        end else if (r_act == ACT_SWAP) begin
                            f_go   = 1'b0;
                            x_swap = 1'b1;
                            f_wr   = 1'b1;
                            f_addr = addr_nxt;
                            f_data = r_rd_top;
                        end else if (r_act == ACT_DIV || r_act == ACT_MOD) begin
                            f_go  = 1'b0;
                            x_div = 1'b1;
                        end else begin
                            f_wr   = 1'b1;
                            f_addr = addr_nxt;
                            f_data = alu;
                            f_top  = alu;
                            f_sp   = r_sp - SP_W'(1);
                        end
                    end
                    ACT_INC, ACT_DEC, ACT_NOT, ACT_POP, ACT_EXP, ACT_PEEK: begin
                        f_yld = (r_act == ACT_PEEK);
                        if (!has1) begin
                            f_err = ERR_UFLOW;
                            f_yld = 1'b1;
                        end else begin
                            unique case (r_act)
                                ACT_INC: begin
                                    f_wr   = 1'b1;
                                    f_data = r_rd_top + WORD_W'(1);
                                end
                                ACT_DEC: begin
                                    f_wr   = 1'b1;
                                    f_data = r_rd_top - WORD_W'(1);
                                end
                                ACT_NOT: begin
                                    f_wr   = 1'b1;
                                    f_data = ~r_rd_top;
                                end
                                ACT_POP: begin
                                    f_sp  = r_sp - SP_W'(1);
                                    f_top = r_rd_nxt;
                                end
                                ACT_EXP: begin
                                    if (r_rd_top[WORD_W-1] ||
                                        r_rd_top[WORD_W-2:0] >= (WORD_W-1)'(WORD_W)) begin
                                        f_err = ERR_RANGE;
                                    end else begin
                                        f_wr   = 1'b1;
                                        f_data = WORD_W'(1) << r_rd_top[4:0];
                                    end
                                end
                                default: begin
                                end
                            endcase
                            f_top = f_wr ? f_data : f_top;
                        end
                    end
                    ACT_PUSH, ACT_DIGIT: begin
                        if (full) begin
                            f_err = ERR_FULL;
                        end else begin
                            f_wr   = 1'b1;
                            f_addr = r_sp[ADDR_W-1:0];
                            f_data = (r_act == ACT_PUSH) ? r_pv : (r_pv - ASCII_ZERO);
                            f_top  = f_data;
                            f_sp   = r_sp + SP_W'(1);
                        end
                    end
                    ACT_DUP: begin
                        if (!has1) begin
                            f_err = ERR_UFLOW;
                            f_yld = 1'b1;
                        end else if (full) begin
                            f_err = ERR_FULL;
                        end else begin
                            f_wr   = 1'b1;
                            f_addr = r_sp[ADDR_W-1:0];
                            f_sp   = r_sp + SP_W'(1);
                        end
                    end
                    ACT_INDEX: begin
                        if (!has1) begin
                            f_err = ERR_UFLOW;
                            f_yld = 1'b1;
                        end else if (r_rd_top[WORD_W-1] ||
                                     r_rd_top[WORD_W-2:0] >=
                                     (WORD_W-1)'(r_sp - SP_W'(1))) begin
                            f_err = ERR_RANGE;
                        end else begin
                            f_go  = 1'b0;
                            x_idx = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SWP: begin
                f_go   = 1'b1;
                f_wr   = 1'b1;
                f_data = r_rd_nxt;
                f_top  = r_rd_nxt;
            end
            S_IDX: begin
                f_go  = 1'b1;
                f_wr  = 1'b1;
                f_top = r_rd_top;
            end
            S_DIV: begin
                f_go   = div_done;
                f_wr   = div_done;
                f_addr = addr_nxt;
                f_data = div_res;
                f_top  = div_res;
                f_sp   = r_sp - SP_W'(1);
            end
            default: begin
            end
        endcase
    end

    // stack memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (f_wr && ((f_go && free) || x_swap)) begin
            mem[f_addr] <= f_data;
        end
        if (r_state == S_IDLE) begin
            r_rd_top <= mem[addr_top];
            r_rd_nxt <= mem[addr_nxt];
        end else if (x_idx) begin
            r_rd_top <= mem[addr_idx];
        end
    end

    // sequencer, divider and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_act   <= i_in_data.action;
                        r_pv    <= i_in_data.push_value;
                        r_state <= S_EX;
                    end
                end
                S_EX: begin
                    if (x_swap) begin
                        r_state <= S_SWP;
                    end else if (x_idx) begin
                        r_state <= S_IDX;
                    end else if (x_div) begin
                        r_quo   <= r_rd_nxt[WORD_W-1] ? (WORD_W'(0) - r_rd_nxt) : r_rd_nxt;
                        r_dvs   <= r_rd_top[WORD_W-1] ? (WORD_W'(0) - r_rd_top) : r_rd_top;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_qneg  <= r_rd_nxt[WORD_W-1] ^ r_rd_top[WORD_W-1];
                        r_rneg  <= r_rd_nxt[WORD_W-1];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!div_done) begin
                        r_cnt <= r_cnt + 5'd1;
                        if (!rem_sub[WORD_W]) begin
                            r_rem <= rem_sub[WORD_W-1:0];
                            r_quo <= {r_quo[WORD_W-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh[WORD_W-1:0];
                            r_quo <= {r_quo[WORD_W-2:0], 1'b0};
                        end
                    end
                end
                default: begin
                end
            endcase
            // commit the item once the output register is free
            if (f_go && free) begin
                r_sp                    <= f_sp;
                r_state                 <= S_IDLE;
                o_out_valid             <= 1'b1;
                o_out_data.top_value    <= (f_sp == '0) ? '0 : f_top;
                o_out_data.top_negative <= (f_sp != '0) && f_top[WORD_W-1];
                o_out_data.depth        <= f_sp;
                o_out_data.error_code   <= f_err;
                o_out_data.yield        <= f_yld;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/core/sa24_chk.sv]
// sa24_chk: port-level checks on the stack alu result items
// depends on sa24_pkg, binds to stack_alu_24bit_top
`default_nettype none
module sa24_chk (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  o_out_valid,
    input  wire                  i_out_ready,
    input  sa24_pkg::t_out_item  o_out_data
);
    import sa24_pkg::*;

    // depth never beyond the stack size
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.depth <= SP_W'(DEPTH))
        else $error("depth beyond stack size");

    // empty stack shows a zero top
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.depth == '0) |->
        (o_out_data.top_value == '0 && !o_out_data.top_negative))
        else $error("empty stack with nonzero top");

    // branch test follows the top sign
    a_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.top_negative == o_out_data.top_value[WORD_W-1])
        else $error("top_negative mismatch");

    // yield with an error only on underflow
    a_yield: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.yield && o_out_data.error_code != ERR_OK) |->
        o_out_data.error_code == ERR_UFLOW)
        else $error("yield with wrong error");

    // stalled result item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled item changed");

endmodule

bind stack_alu_24bit_top sa24_chk u_sa24_chk (.*);
`default_nettype wire
